@@ hw/rtl/assert_macros.svh @@
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hw/rtl/krt_pkg.sv @@
package krt_pkg;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_READ = 2'd2,
    KIND_LIST = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  year;
    logic [15:0] first_course;
    logic [7:0]  first_grade;
    logic [15:0] second_course;
    logic [7:0]  second_grade;
    logic [15:0] third_course;
    logic [7:0]  third_grade;
  } rec_t;

  // broadcast controls for the cell row
  typedef struct packed {
    logic add;
    logic del;
    logic lst_load;
    logic lst_shift;
  } cell_ctl_t;

endpackage

@@ hw/rtl/krt_cell.sv @@
module krt_cell
  import krt_pkg::*;
(
  input  logic        clk,
  input  cell_ctl_t   ctl,
  input  logic        add_here,
  input  logic        occupied,
  input  logic [31:0] srch_key,
  input  rec_t        in_rec,
  input  rec_t        nbr_rec,
  input  logic [31:0] nbr_lst,
  input  logic        prev_hit,
  output logic        hit_out,
  output logic        first,
  output rec_t        rec,
  output logic [31:0] lst
);

  rec_t        rec_r;
  logic [31:0] lst_r;
  logic        hit;

  assign hit     = occupied && (rec_r.key == srch_key);
  assign hit_out = prev_hit | hit;
  assign first   = hit & ~prev_hit;
  assign rec     = rec_r;
  assign lst     = lst_r;

  // a delete closes the gap: every cell from the match upward takes its neighbor
  always_ff @(posedge clk) begin
    if (ctl.add && add_here) begin
      rec_r <= in_rec;
    end else if (ctl.del && hit_out) begin
      rec_r <= nbr_rec;
    end
    if (ctl.lst_load) begin
      lst_r <= rec_r.key;
    end else if (ctl.lst_shift) begin
      lst_r <= nbr_lst;
    end
  end

endmodule

@@ hw/rtl/keyed_record_table.sv @@
// keyed record table: a row of CAPACITY cells, one record each, in insertion order.
// a request is taken at a rising edge with start high and busy low; the in_kind
// port picks add, delete, read or list, the other in_ ports carry the key and
// the record for an add.
// add, delete and read: one result with out_last high, strobed in the cycle after
// the request; the row compares all keys at once and a delete shifts the later
// cells down in that same edge, so these may follow back to back.
// list: keys are copied into a second chain that shifts toward cell 0, one key
// per cycle; the request sets busy and loads the chain, then results come from
// the output registers one per cycle, and busy stays high until the final key
// (out_last) is out. an empty table gives one result with status empty.
// out_entry_count is the record count after the request.
// results appear for exactly one cycle on out_strobe; the receiver cannot stall.
// reset empties the table and clears any list in progress.
module keyed_record_table
  import krt_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_key,
  input  logic [7:0]  in_year,
  input  logic [15:0] in_first_course,
  input  logic [7:0]  in_first_grade,
  input  logic [15:0] in_second_course,
  input  logic [7:0]  in_second_grade,
  input  logic [15:0] in_third_course,
  input  logic [7:0]  in_third_grade,
  output logic        out_strobe,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_key,
  output logic [7:0]  out_found_year,
  output logic [15:0] out_found_first_course,
  output logic [7:0]  out_found_first_grade,
  output logic [15:0] out_found_second_course,
  output logic [7:0]  out_found_second_grade,
  output logic [15:0] out_found_third_course,
  output logic [7:0]  out_found_third_grade,
  output logic [4:0]  out_entry_count,
  output logic        out_last
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             listing_r, listing_nxt;
  logic             strobe_r, strobe_nxt;
  logic             last_r, last_nxt;
  status_t          status_r, status_nxt;
  rec_t             out_rec_r, out_rec_nxt;

  cell_ctl_t        ctl;
  kind_t            kind;
  logic             accept;
  logic             full;
  logic             found;
  rec_t             in_rec;
  rec_t             rd_rec;

  rec_t             cell_rec [CAPACITY];
  logic [31:0]      cell_lst [CAPACITY];
  logic             cell_hit [CAPACITY];
  logic             cell_first [CAPACITY];

  assign kind   = kind_t'(in_kind);
  assign busy   = listing_r;
  assign accept = start & ~listing_r;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign found  = cell_hit[CAPACITY-1];

  always_comb begin
    in_rec.key           = in_key;
    in_rec.year          = in_year;
    in_rec.first_course  = in_first_course;
    in_rec.first_grade   = in_first_grade;
    in_rec.second_course = in_second_course;
    in_rec.second_grade  = in_second_grade;
    in_rec.third_course  = in_third_course;
    in_rec.third_grade   = in_third_grade;
  end

  always_comb begin
    ctl.add       = accept && (kind == KIND_ADD) && !full;
    ctl.del       = accept && (kind == KIND_DEL) && found;
    ctl.lst_load  = accept && (kind == KIND_LIST) && (count_r != '0);
    ctl.lst_shift = listing_r;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    krt_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .add_here (count_r == CNT_W'(i)),
      .occupied (CNT_W'(i) < count_r),
      .srch_key (in_key),
      .in_rec   (in_rec),
      .nbr_rec  (cell_rec[(i + 1 < CAPACITY) ? i + 1 : i]),
      .nbr_lst  (cell_lst[(i + 1 < CAPACITY) ? i + 1 : i]),
      .prev_hit ((i == 0) ? 1'b0 : cell_hit[(i == 0) ? 0 : i - 1]),
      .hit_out  (cell_hit[i]),
      .first    (cell_first[i]),
      .rec      (cell_rec[i]),
      .lst      (cell_lst[i])
    );
  end

  // at most one cell flags first, so an or over the row selects it
  always_comb begin
    rd_rec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_first[i]) begin
        rd_rec = rd_rec | cell_rec[i];
      end
    end
  end

  always_comb begin
    count_nxt   = count_r;
    left_nxt    = left_r;
    listing_nxt = listing_r;
    strobe_nxt  = 1'b0;
    last_nxt    = 1'b1;
    status_nxt  = ST_OK;
    out_rec_nxt = '0;
    out_rec_nxt.key = in_key;
    if (listing_r) begin
      strobe_nxt      = 1'b1;
      out_rec_nxt.key = cell_lst[0];
      last_nxt        = (left_r == CNT_W'(1));
      listing_nxt     = (left_r != CNT_W'(1));
      left_nxt        = left_r - CNT_W'(1);
    end else if (accept) begin
      strobe_nxt = 1'b1;
      unique case (kind)
        KIND_ADD: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
        KIND_DEL: begin
          if (found) begin
            count_nxt = count_r - CNT_W'(1);
          end else begin
            status_nxt = ST_MISSING;
          end
        end
        KIND_READ: begin
          if (found) begin
            out_rec_nxt = rd_rec;
          end else begin
            status_nxt = ST_MISSING;
          end
        end
        KIND_LIST: begin
          if (count_r == '0) begin
            status_nxt      = ST_EMPTY;
            out_rec_nxt.key = '0;
          end else begin
            // the first key comes out of the list chain on the next cycle
            strobe_nxt  = 1'b0;
            listing_nxt = 1'b1;
            left_nxt    = count_r;
          end
        end
        default: begin
          strobe_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      left_r    <= '0;
      listing_r <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      left_r    <= left_nxt;
      listing_r <= listing_nxt;
      strobe_r  <= strobe_nxt;
    end
    last_r    <= last_nxt;
    status_r  <= status_nxt;
    out_rec_r <= out_rec_nxt;
  end

  logic [CNT_W+4:0] count_ext;
  assign count_ext = {5'd0, count_r};

  assign out_strobe              = strobe_r;
  assign out_status              = status_r;
  assign out_found_key           = out_rec_r.key;
  assign out_found_year          = out_rec_r.year;
  assign out_found_first_course  = out_rec_r.first_course;
  assign out_found_first_grade   = out_rec_r.first_grade;
  assign out_found_second_course = out_rec_r.second_course;
  assign out_found_second_grade  = out_rec_r.second_grade;
  assign out_found_third_course  = out_rec_r.third_course;
  assign out_found_third_grade   = out_rec_r.third_grade;
  assign out_entry_count         = count_ext[4:0];
  assign out_last                = last_r;

endmodule

@@ hw/rtl/krt_checker.sv @@
`include "assert_macros.svh"

module krt_checker
  import krt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_kind,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [4:0]  out_entry_count,
  input logic        out_last
);

  logic accept;
  assign accept = start && !busy;

  // a list stream has no gaps
  `ASSERT_NXT(a_stream_gapless, clk, rst_n, out_strobe && !out_last, out_strobe)
  // no new request may be taken in the middle of a list stream
  `ASSERT_IMP(a_busy_in_stream, clk, rst_n, out_strobe && !out_last, busy)
  // single-result requests answer in the next cycle
  `ASSERT_NXT(a_single_next, clk, rst_n, accept && (in_kind != KIND_LIST),
              out_strobe && out_last)
  // an empty list reports zero records in one result
  `ASSERT_IMP(a_empty_list, clk, rst_n, out_strobe && (out_status == ST_EMPTY),
              out_last && (out_entry_count == 5'd0))

endmodule

bind keyed_record_table krt_checker u_krt_checker (.*);

@@ tb/keyed_record_table_tb.sv @@
module keyed_record_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import krt_pkg::*;

  localparam int TBL_DEPTH = 16;
  localparam int RANDOM_REQUESTS = 444;
  localparam int CALM_TAIL = 60;
  localparam int DIR_COUNT = 26;

  typedef struct packed {
    status_t    status;
    rec_t       rec;
    logic [4:0] count;
    logic       is_last;
  } reply_t;

  typedef struct {
    kind_t       kind;
    rec_t        req;
    bit          typed;
    status_t     t_status;
    logic [31:0] t_key;
    logic [4:0]  t_count;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_kind;
  logic [31:0] in_key;
  logic [7:0]  in_year;
  logic [15:0] in_first_course;
  logic [7:0]  in_first_grade;
  logic [15:0] in_second_course;
  logic [7:0]  in_second_grade;
  logic [15:0] in_third_course;
  logic [7:0]  in_third_grade;
  logic        out_strobe;
  logic [1:0]  out_status;
  logic [31:0] out_found_key;
  logic [7:0]  out_found_year;
  logic [15:0] out_found_first_course;
  logic [7:0]  out_found_first_grade;
  logic [15:0] out_found_second_course;
  logic [7:0]  out_found_second_grade;
  logic [15:0] out_found_third_course;
  logic [7:0]  out_found_third_grade;
  logic [4:0]  out_entry_count;
  logic        out_last;

  // shadow copy of the record row
  rec_t   shadow_rows [TBL_DEPTH];
  int     shadow_used;
  reply_t pending_replies [$];

  int fail_count;
  int requests_sent;
  int replies_checked;
  int full_refusals;
  int empty_lists;
  int delete_hits;

  dir_row_t dir_rows [DIR_COUNT] = '{
    '{KIND_LIST, '0, 1'b1, ST_EMPTY, 32'h0000_0000, 5'd0},
    '{KIND_READ, '0, 1'b1, ST_MISSING, 32'h0000_0000, 5'd0},
    '{KIND_DEL, '{32'hFFFF_FFFF, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00, 16'h0000, 8'h00},
      1'b1, ST_MISSING, 32'hFFFF_FFFF, 5'd0},
    '{KIND_ADD, '0, 1'b1, ST_OK, 32'h0000_0000, 5'd1},
    '{KIND_ADD, '1, 1'b1, ST_OK, 32'hFFFF_FFFF, 5'd2},
    // duplicate of key zero
    '{KIND_ADD, '{32'h0000_0000, 8'h5A, 16'h1234, 8'h56, 16'h789A, 8'hBC, 16'hDEF0, 8'h11},
      1'b1, ST_OK, 32'h0000_0000, 5'd3},
    '{KIND_ADD, '{32'h0000_0106, 8'd6, 16'h0600, 8'd60, 16'h0601, 8'd61, 16'h0602, 8'd62},
      1'b1, ST_OK, 32'h0000_0106, 5'd4},
    '{KIND_ADD, '{32'h0000_0107, 8'd7, 16'h0700, 8'd70, 16'h0701, 8'd71, 16'h0702, 8'd72},
      1'b1, ST_OK, 32'h0000_0107, 5'd5},
    '{KIND_ADD, '{32'h0000_0108, 8'd8, 16'h0800, 8'd80, 16'h0801, 8'd81, 16'h0802, 8'd82},
      1'b1, ST_OK, 32'h0000_0108, 5'd6},
    '{KIND_ADD, '{32'h0000_0109, 8'd9, 16'h0900, 8'd90, 16'h0901, 8'd91, 16'h0902, 8'd92},
      1'b1, ST_OK, 32'h0000_0109, 5'd7},
    '{KIND_ADD, '{32'h0000_010A, 8'd10, 16'h0A00, 8'd100, 16'h0A01, 8'd101, 16'h0A02, 8'd102},
      1'b1, ST_OK, 32'h0000_010A, 5'd8},
    '{KIND_ADD, '{32'h0000_010B, 8'd11, 16'h0B00, 8'd110, 16'h0B01, 8'd111, 16'h0B02, 8'd112},
      1'b1, ST_OK, 32'h0000_010B, 5'd9},
    '{KIND_ADD, '{32'h0000_010C, 8'd12, 16'h0C00, 8'd120, 16'h0C01, 8'd121, 16'h0C02, 8'd122},
      1'b1, ST_OK, 32'h0000_010C, 5'd10},
    '{KIND_ADD, '{32'h0000_010D, 8'd13, 16'h0D00, 8'd130, 16'h0D01, 8'd131, 16'h0D02, 8'd132},
      1'b1, ST_OK, 32'h0000_010D, 5'd11},
    '{KIND_ADD, '{32'h0000_010E, 8'd14, 16'h0E00, 8'd140, 16'h0E01, 8'd141, 16'h0E02, 8'd142},
      1'b1, ST_OK, 32'h0000_010E, 5'd12},
    '{KIND_ADD, '{32'h0000_010F, 8'd15, 16'h0F00, 8'd150, 16'h0F01, 8'd151, 16'h0F02, 8'd152},
      1'b1, ST_OK, 32'h0000_010F, 5'd13},
    '{KIND_ADD, '{32'h0000_0110, 8'd16, 16'h1000, 8'd160, 16'h1001, 8'd161, 16'h1002, 8'd162},
      1'b1, ST_OK, 32'h0000_0110, 5'd14},
    '{KIND_ADD, '{32'h0000_0111, 8'd17, 16'h1100, 8'd170, 16'h1101, 8'd171, 16'h1102, 8'd172},
      1'b1, ST_OK, 32'h0000_0111, 5'd15},
    '{KIND_ADD, '{32'h0000_0112, 8'd18, 16'h1200, 8'd180, 16'h1201, 8'd181, 16'h1202, 8'd182},
      1'b1, ST_OK, 32'h0000_0112, 5'd16},
    // table is full now
    '{KIND_ADD, '{32'h8000_0001, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF},
      1'b1, ST_FULL, 32'h8000_0001, 5'd16},
    '{KIND_LIST, '0, 1'b0, ST_OK, 32'h0, 5'd0},
    '{KIND_READ, '0, 1'b0, ST_OK, 32'h0, 5'd0},
    '{KIND_DEL, '0, 1'b1, ST_OK, 32'h0000_0000, 5'd15},
    '{KIND_READ, '0, 1'b0, ST_OK, 32'h0, 5'd0},
    '{KIND_DEL, '1, 1'b1, ST_OK, 32'hFFFF_FFFF, 5'd14},
    '{KIND_READ, '1, 1'b1, ST_MISSING, 32'hFFFF_FFFF, 5'd14}
  };

  keyed_record_table #(
    .CAPACITY(TBL_DEPTH)
  ) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .start                  (start),
    .busy                   (busy),
    .in_kind                (in_kind),
    .in_key                 (in_key),
    .in_year                (in_year),
    .in_first_course        (in_first_course),
    .in_first_grade         (in_first_grade),
    .in_second_course       (in_second_course),
    .in_second_grade        (in_second_grade),
    .in_third_course        (in_third_course),
    .in_third_grade         (in_third_grade),
    .out_strobe             (out_strobe),
    .out_status             (out_status),
    .out_found_key          (out_found_key),
    .out_found_year         (out_found_year),
    .out_found_first_course (out_found_first_course),
    .out_found_first_grade  (out_found_first_grade),
    .out_found_second_course(out_found_second_course),
    .out_found_second_grade (out_found_second_grade),
    .out_found_third_course (out_found_third_course),
    .out_found_third_grade  (out_found_third_grade),
    .out_entry_count        (out_entry_count),
    .out_last               (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // applies one request to the shadow rows and, when keep is set, queues the replies it causes
  task automatic apply_table_request(input kind_t kind, input rec_t req, input bit keep);
    reply_t r;
    reply_t outs [$];
    int hit;
    hit = -1;
    for (int i = 0; i < shadow_used; i++) begin
      if (hit < 0 && shadow_rows[i].key == req.key) hit = i;
    end
    r = '0;
    r.status = ST_OK;
    r.rec.key = req.key;
    r.is_last = 1'b1;
    case (kind)
      KIND_ADD: begin
        if (shadow_used == TBL_DEPTH) begin
          r.status = ST_FULL;
          full_refusals++;
        end else begin
          shadow_rows[shadow_used] = req;
          shadow_used++;
        end
      end
      KIND_DEL: begin
        if (hit < 0) begin
          r.status = ST_MISSING;
        end else begin
          for (int i = hit; i + 1 < shadow_used; i++) shadow_rows[i] = shadow_rows[i + 1];
          shadow_used--;
          delete_hits++;
        end
      end
      KIND_READ: begin
        if (hit < 0) r.status = ST_MISSING;
        else r.rec = shadow_rows[hit];
      end
      default: begin
        if (shadow_used == 0) begin
          r.status = ST_EMPTY;
          r.rec.key = '0;
          empty_lists++;
        end
      end
    endcase
    r.count = 5'(shadow_used);
    if (kind == KIND_LIST && shadow_used > 0) begin
      for (int i = 0; i < shadow_used; i++) begin
        r.rec = '0;
        r.rec.key = shadow_rows[i].key;
        r.is_last = (i == shadow_used - 1);
        outs.push_back(r);
      end
    end else begin
      outs.push_back(r);
    end
    if (keep) begin
      foreach (outs[i]) pending_replies.push_back(outs[i]);
    end
  endtask

  // holds start low first if gap is nonzero, then presents the request until it is taken
  task automatic send_request(input kind_t kind, input rec_t req, input int gap,
                              input bit typed, input reply_t typed_reply);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_kind          <= kind;
    in_key           <= req.key;
    in_year          <= req.year;
    in_first_course  <= req.first_course;
    in_first_grade   <= req.first_grade;
    in_second_course <= req.second_course;
    in_second_grade  <= req.second_grade;
    in_third_course  <= req.third_course;
    in_third_grade   <= req.third_grade;
    do @(posedge clk); while (busy);
    apply_table_request(kind, req, !typed);
    if (typed) pending_replies.push_back(typed_reply);
    requests_sent++;
  endtask

  function automatic logic [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (shadow_used > 0 && roll < 60) return shadow_rows[$urandom_range(0, shadow_used - 1)].key;
    if (roll < 75) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom;
  endfunction

  // mode 0 fills the table, mode 1 drains it, mode 2 mixes
  function automatic kind_t pick_kind(input int mode);
    int roll;
    roll = $urandom_range(0, 99);
    case (mode)
      0: return roll < 60 ? KIND_ADD : roll < 70 ? KIND_DEL : roll < 92 ? KIND_READ : KIND_LIST;
      1: return roll < 10 ? KIND_ADD : roll < 65 ? KIND_DEL : roll < 92 ? KIND_READ : KIND_LIST;
      default:
        return roll < 32 ? KIND_ADD : roll < 58 ? KIND_DEL : roll < 92 ? KIND_READ : KIND_LIST;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_strobe) begin
      if (pending_replies.size() == 0) begin
        $error("reply with no request outstanding: status %0d key %0h", out_status,
               out_found_key);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("found_key", want.rec.key, out_found_key);
        check_field("found_year", 32'(want.rec.year), 32'(out_found_year));
        check_field("found_first_course", 32'(want.rec.first_course),
                    32'(out_found_first_course));
        check_field("found_first_grade", 32'(want.rec.first_grade),
                    32'(out_found_first_grade));
        check_field("found_second_course", 32'(want.rec.second_course),
                    32'(out_found_second_course));
        check_field("found_second_grade", 32'(want.rec.second_grade),
                    32'(out_found_second_grade));
        check_field("found_third_course", 32'(want.rec.third_course),
                    32'(out_found_third_course));
        check_field("found_third_grade", 32'(want.rec.third_grade),
                    32'(out_found_third_grade));
        check_field("entry_count", 32'(want.count), 32'(out_entry_count));
        check_field("last", 32'(want.is_last), 32'(out_last));
      end
    end
  end

  initial begin
    #200_000;
    $display("keyed_record_table_tb: FAIL");
    $finish;
  end

  initial begin
    kind_t          kind;
    rec_t           req;
    reply_t         typed_reply;
    logic [127:0]   noise;
    int             gap;
    int             quiet_left;
    int             mode;
    int             mode_left;
    fail_count       = 0;
    requests_sent    = 0;
    replies_checked  = 0;
    full_refusals    = 0;
    empty_lists      = 0;
    delete_hits      = 0;
    shadow_used      = 0;
    quiet_left       = 0;
    mode             = 0;
    mode_left        = 0;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_kind          <= KIND_ADD;
    in_key           <= '0;
    in_year          <= '0;
    in_first_course  <= '0;
    in_first_grade   <= '0;
    in_second_course <= '0;
    in_second_grade  <= '0;
    in_third_course  <= '0;
    in_third_grade   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      typed_reply = '0;
      typed_reply.status = dir_rows[i].t_status;
      typed_reply.rec.key = dir_rows[i].t_key;
      typed_reply.count = dir_rows[i].t_count;
      typed_reply.is_last = 1'b1;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      send_request(dir_rows[i].kind, dir_rows[i].req, gap, dir_rows[i].typed, typed_reply);
    end

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      kind = pick_kind(mode);
      noise = {$urandom, $urandom, $urandom, $urandom};
      req = noise[111:0];
      if ($urandom_range(0, 4) != 0) req.key = pick_key();
      // idle bursts, with quiet stretches and none near the end
      gap = 0;
      if (n < RANDOM_REQUESTS - CALM_TAIL) begin
        if (quiet_left > 0) begin
          quiet_left--;
        end else if ($urandom_range(0, 19) == 0) begin
          quiet_left = $urandom_range(10, 30);
        end else if ($urandom_range(0, 3) == 0) begin
          gap = $urandom_range(1, 11);
        end
      end
      send_request(kind, req, gap, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("%0d requests sent, %0d replies checked", requests_sent, replies_checked);
    $display("%0d adds refused on a full table, %0d lists of an empty table, %0d deletes hit",
             full_refusals, empty_lists, delete_hits);
    if (fail_count == 0 && pending_replies.size() == 0) begin
      $display("keyed_record_table_tb: PASS");
    end else begin
      $display("keyed_record_table_tb: FAIL");
    end
    $finish;
  end

endmodule
